FILE: rtl/ultrasonic_echo_ranger_macros.svh
// assertion macros used by the echo ranger top level
`ifndef ULTRASONIC_ECHO_RANGER_MACROS_SVH
`define ULTRASONIC_ECHO_RANGER_MACROS_SVH

// same-cycle implication, checked out of reset
`define UER_ASSERT_NOW(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("echo ranger check failed");

// next-cycle implication, checked out of reset
`define UER_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("echo ranger check failed");

`endif

FILE: rtl/uer_pkg.sv
// types, constants and codes shared by the echo ranger modules
`default_nettype none

package uer_pkg;

    // width of the microsecond counter
    localparam int TIME_BITS = 16;
    typedef logic [TIME_BITS-1:0] us_count_t;
    localparam us_count_t TIME_MAX = '1;

    // measurement phases
    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_PRE_LOW   = 3'd1,
        PH_TRIG_HIGH = 3'd2,
        PH_WAIT_RISE = 3'd3,
        PH_MEASURE   = 3'd4
    } phase_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_CYCLES_PER_US = 2'd0,
        CFG_TIMEOUT_US    = 2'd1,
        CFG_PRE_LOW_US    = 2'd2,
        CFG_TRIG_HIGH_US  = 2'd3
    } cfg_index_t;

    localparam int CFG_DATA_W = 16;

    // configuration reset values
    localparam logic [7:0]  RST_CYCLES_PER_US = 8'd96;
    localparam logic [15:0] RST_TIMEOUT_US    = 16'd30000;
    localparam logic [7:0]  RST_PRE_LOW_US    = 8'd5;
    localparam logic [7:0]  RST_TRIG_HIGH_US  = 8'd10;

    // one configuration write
    typedef struct packed {
        logic                  valid;
        cfg_index_t            index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_wr_t;

    // stream widths
    localparam int IN_TDATA_W  = 8;
    localparam int DIST_W      = 16;
    localparam int OUT_TDATA_W = 24;

    // classified item passed from front to back
    typedef struct packed {
        logic      trig;
        logic      busy;
        logic      done;
        logic      timed_out;
        us_count_t echo_us;
    } meas_item_t;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // distance arithmetic: (us*100 + 29) / 58 by reciprocal multiply
    localparam int N_BITS      = TIME_BITS + 7;
    localparam int RECIP_BITS  = 27;
    localparam int RECIP_SHIFT = 32;
    localparam int P_BITS      = N_BITS + RECIP_BITS;
    localparam int Q_BITS      = P_BITS - RECIP_SHIFT;
    localparam logic [RECIP_BITS-1:0] RECIP = 27'd74051160;
    localparam logic [6:0] SCALE    = 7'd100;
    localparam logic [6:0] ROUND    = 7'd29;
    localparam logic [6:0] DIVISOR  = 7'd58;

endpackage

`default_nettype wire

FILE: rtl/uer_front.sv
// front: config registers, prescaler and measurement phase machine
`default_nettype none

module uer_front
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire uer_pkg::cfg_wr_t   cfg_wr,
    input  wire logic               accept,
    input  wire logic               echo_level,
    input  wire logic               start_request,
    output uer_pkg::meas_item_t     item
);
    import uer_pkg::*;

    logic [7:0]  cycles_per_us_reg;
    logic [15:0] timeout_us_reg;
    logic [7:0]  pre_low_us_reg;
    logic [7:0]  trig_high_us_reg;

    phase_t      phase_reg, phase_next;
    logic [7:0]  prescale_reg, prescale_next;
    us_count_t   elapsed_reg, elapsed_next;

    logic [7:0]  div;
    logic        tick;
    logic [7:0]  adv_prescale;
    us_count_t   adv_elapsed;
    logic        done;
    logic        timed_out;
    us_count_t   meas_us;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cycles_per_us_reg <= RST_CYCLES_PER_US;
            timeout_us_reg    <= RST_TIMEOUT_US;
            pre_low_us_reg    <= RST_PRE_LOW_US;
            trig_high_us_reg  <= RST_TRIG_HIGH_US;
        end
        else if (cfg_wr.valid)
        begin
            case (cfg_wr.index)
                CFG_CYCLES_PER_US: cycles_per_us_reg <= cfg_wr.data[7:0];
                CFG_TIMEOUT_US:    timeout_us_reg    <= cfg_wr.data;
                CFG_PRE_LOW_US:    pre_low_us_reg    <= cfg_wr.data[7:0];
                CFG_TRIG_HIGH_US:  trig_high_us_reg  <= cfg_wr.data[7:0];
                default:           ;
            endcase
        end
    end

    // phase and timer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            prescale_reg <= '0;
            elapsed_reg  <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            prescale_reg <= prescale_next;
            elapsed_reg  <= elapsed_next;
        end
    end

    // microsecond prescaler, zero divisor counts as one
    always_comb
    begin
        div          = (cycles_per_us_reg == 8'd0) ? 8'd1 : cycles_per_us_reg;
        tick         = ({1'b0, prescale_reg} + 9'd1) >= {1'b0, div};
        adv_prescale = tick ? 8'd0 : prescale_reg + 8'd1;
        adv_elapsed  = (tick && elapsed_reg != TIME_MAX) ? elapsed_reg + 1'b1 : elapsed_reg;
    end

    // next phase and classification of the item
    always_comb
    begin
        phase_next    = phase_reg;
        prescale_next = prescale_reg;
        elapsed_next  = elapsed_reg;
        done          = 1'b0;
        timed_out     = 1'b0;
        meas_us       = '0;
        if (accept)
        begin
            case (phase_reg)
                PH_PRE_LOW:
                begin
                    prescale_next = adv_prescale;
                    elapsed_next  = adv_elapsed;
                    if (adv_elapsed >= us_count_t'(pre_low_us_reg))
                    begin
                        phase_next    = PH_TRIG_HIGH;
                        prescale_next = '0;
                        elapsed_next  = '0;
                    end
                end
                PH_TRIG_HIGH:
                begin
                    prescale_next = adv_prescale;
                    elapsed_next  = adv_elapsed;
                    if (adv_elapsed >= us_count_t'(trig_high_us_reg))
                    begin
                        phase_next    = PH_WAIT_RISE;
                        prescale_next = '0;
                        elapsed_next  = '0;
                    end
                end
                PH_WAIT_RISE:
                begin
                    if (echo_level)
                    begin
                        phase_next    = PH_MEASURE;
                        prescale_next = '0;
                        elapsed_next  = '0;
                    end
                    else
                    begin
                        prescale_next = adv_prescale;
                        elapsed_next  = adv_elapsed;
                        if (adv_elapsed >= us_count_t'(timeout_us_reg))
                        begin
                            done          = 1'b1;
                            timed_out     = 1'b1;
                            phase_next    = PH_IDLE;
                            prescale_next = '0;
                            elapsed_next  = '0;
                        end
                    end
                end
                PH_MEASURE:
                begin
                    if (!echo_level)
                    begin
                        done          = 1'b1;
                        meas_us       = elapsed_reg;
                        phase_next    = PH_IDLE;
                        prescale_next = '0;
                        elapsed_next  = '0;
                    end
                    else
                    begin
                        prescale_next = adv_prescale;
                        elapsed_next  = adv_elapsed;
                        if (adv_elapsed >= us_count_t'(timeout_us_reg))
                        begin
                            done          = 1'b1;
                            timed_out     = 1'b1;
                            phase_next    = PH_IDLE;
                            prescale_next = '0;
                            elapsed_next  = '0;
                        end
                    end
                end
                default:
                begin
                    // idle and unused codes: a start opens a run
                    phase_next    = start_request ? PH_PRE_LOW : PH_IDLE;
                    prescale_next = '0;
                    elapsed_next  = '0;
                end
            endcase
        end
    end

    // item for the back end, flags reflect the state after this cycle
    always_comb
    begin
        item.trig      = (phase_next == PH_TRIG_HIGH);
        item.busy      = (phase_next != PH_IDLE);
        item.done      = done;
        item.timed_out = timed_out;
        item.echo_us   = meas_us;
    end

endmodule

`default_nettype wire

FILE: rtl/uer_queue.sv
// short queue that decouples the phase machine from the distance pipeline
`default_nettype none

module uer_queue
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push_valid,
    output logic                       push_ready,
    input  wire uer_pkg::meas_item_t   push_item,
    output logic                       pop_valid,
    input  wire logic                  pop_ready,
    output uer_pkg::meas_item_t        pop_item
);
    import uer_pkg::*;

    meas_item_t        entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic              do_push;
    logic              do_pop;

    // handshakes
    assign push_ready = (count_reg != (QPTR_W+1)'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/uer_back.sv
// back: distance pipeline with reciprocal divide and output register
`default_nettype none

module uer_back
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire uer_pkg::meas_item_t            in_item,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output logic [uer_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
    import uer_pkg::*;

    // flags carried alongside the arithmetic
    typedef struct packed {
        logic trig;
        logic busy;
        logic done;
        logic timed_out;
    } flags_t;

    logic                     v1_reg, v2_reg, v3_reg;
    logic                     ready1, ready2, ready3;
    flags_t                   f1_reg, f2_reg;
    logic [N_BITS-1:0]        n1_reg, n2_reg;
    logic [Q_BITS-1:0]        q2_reg;
    logic [OUT_TDATA_W-1:0]   out_reg;

    logic [P_BITS-1:0]        prod;
    logic [N_BITS-1:0]        chk;
    logic [N_BITS-1:0]        rem;
    logic [Q_BITS-1:0]        q_fix;
    logic [DIST_W-1:0]        dist_sat;

    // stage advance: a stage moves when its successor is free or moving
    assign ready3        = !v3_reg || m_axis_tready;
    assign ready2        = !v2_reg || ready3;
    assign ready1        = !v1_reg || ready2;
    assign in_ready      = ready1;
    assign m_axis_tvalid = v3_reg;
    assign m_axis_tdata  = out_reg;

    // reciprocal estimate, low by at most one
    assign prod = P_BITS'(n1_reg) * P_BITS'(RECIP);

    // remainder correction and saturation
    always_comb
    begin
        chk      = N_BITS'(q2_reg) * N_BITS'(DIVISOR);
        rem      = n2_reg - chk;
        q_fix    = (rem >= N_BITS'(DIVISOR)) ? q2_reg + 1'b1 : q2_reg;
        dist_sat = (q_fix > Q_BITS'({DIST_W{1'b1}})) ? {DIST_W{1'b1}} : DIST_W'(q_fix);
    end

    // stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (ready1)
            begin
                v1_reg <= in_valid;
            end
            if (ready2)
            begin
                v2_reg <= v1_reg;
            end
            if (ready3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (ready1 && in_valid)
        begin
            f1_reg <= '{trig: in_item.trig, busy: in_item.busy,
                        done: in_item.done, timed_out: in_item.timed_out};
            n1_reg <= N_BITS'(in_item.echo_us) * N_BITS'(SCALE) + N_BITS'(ROUND);
        end
        if (ready2 && v1_reg)
        begin
            f2_reg <= f1_reg;
            n2_reg <= n1_reg;
            q2_reg <= Q_BITS'(prod >> RECIP_SHIFT);
        end
        if (ready3 && v2_reg)
        begin
            out_reg <= OUT_TDATA_W'({dist_sat, f2_reg.timed_out, f2_reg.done,
                                     f2_reg.busy, f2_reg.trig});
        end
    end

endmodule

`default_nettype wire

FILE: rtl/ultrasonic_echo_ranger.sv
// top level of the ultrasonic echo pulse ranger
//
// Usage: one input item per clock cycle carries the sampled echo pin and a
// start request; every accepted item gives exactly one result item with the
// trigger level, busy, done, timeout flag and distance in hundredths of cm.
// The phase machine and microsecond prescaler run in the front part as each
// item is accepted; a two-entry queue feeds a three-stage back pipeline that
// turns the echo width into distance by reciprocal multiply and correction.
// Each result passes through the queue and the three back stages in order.
// Throughput: one item per cycle; s_axis_tready falls only when the queue is
// full, which happens only after the receiver has stalled m_axis_tready.
// A receiver stall holds the output register and backs up the pipeline and
// queue; no item is lost and the phase machine advances only on accepted
// items. Configuration writes are always accepted (cfg_ready high) and are
// meant to happen while no run is in progress. Reset clears the phase to
// idle, the timers to zero and loads the default configuration.
`default_nettype none

module ultrasonic_echo_ranger
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // [0] echo_level, [1] start_request, [7:2] zero
    input  wire logic [uer_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // [0] trig_drive, [1] busy_res, [2] done_res, [3] timed_out,
    // [19:4] distance_x100, [23:20] zero
    output logic [uer_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire uer_pkg::cfg_index_t                cfg_index,
    input  wire logic [uer_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import uer_pkg::*;

    `include "ultrasonic_echo_ranger_macros.svh"

    cfg_wr_t    cfg_wr;
    logic       accept;
    meas_item_t front_item;
    logic       q_valid;
    logic       q_ready;
    meas_item_t q_item;

    // configuration channel never stalls
    assign cfg_ready     = 1'b1;
    assign cfg_wr.valid  = cfg_valid && cfg_ready;
    assign cfg_wr.index  = cfg_index;
    assign cfg_wr.data   = cfg_data;

    // item accepted when the queue has room
    assign accept = s_axis_tvalid && s_axis_tready;

    uer_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr        (cfg_wr),
        .accept        (accept),
        .echo_level    (s_axis_tdata[0]),
        .start_request (s_axis_tdata[1]),
        .item          (front_item)
    );

    uer_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (s_axis_tvalid),
        .push_ready (s_axis_tready),
        .push_item  (front_item),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_item   (q_item)
    );

    uer_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (q_valid),
        .in_ready      (q_ready),
        .in_item       (q_item),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // a timeout is always a finished run with zero distance
    `UER_ASSERT_NOW(a_tmo_done, clk, rst_n, m_axis_tvalid && m_axis_tdata[3], m_axis_tdata[2])
    `UER_ASSERT_NOW(a_tmo_zero, clk, rst_n, m_axis_tvalid && m_axis_tdata[3], m_axis_tdata[19:4] == 16'd0)
    // trigger only drives during a run
    `UER_ASSERT_NOW(a_trig_busy, clk, rst_n, m_axis_tvalid && m_axis_tdata[0], m_axis_tdata[1])
    // with the queue full and the output blocked, the output stays valid
    `UER_ASSERT_NEXT(a_stall_hold, clk, rst_n, !s_axis_tready && m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

endmodule

`default_nettype wire

FILE: test/ultrasonic_echo_ranger_test.sv
// testbench for the ultrasonic echo ranger: table-driven and random items checked against a cycle model
module ultrasonic_echo_ranger_test;
    timeunit 1ns;
    timeprecision 1ps;

    import uer_pkg::*;

    localparam int LIMIT_CYCLES = 50_000;
    localparam int IDLE_PCT = 21;
    localparam int HOLD_CYCLES = 400;
    localparam int CALM_FROM = 750;
    localparam int CALM_TO = 1_050;
    localparam int SETTINGS_COUNT = 6;
    localparam int ITEMS_PER_SETTING = 30;

    // one result item, packed in the same order as m_axis_tdata[19:0]
    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              timed_out;
        logic              done;
        logic              busy;
        logic              trig;
    } reading_t;

    localparam reading_t IDLE_RD = '0;
    localparam reading_t BUSY_RD =
        '{distance: '0, timed_out: 1'b0, done: 1'b0, busy: 1'b1, trig: 1'b0};
    localparam reading_t TRIG_RD =
        '{distance: '0, timed_out: 1'b0, done: 1'b0, busy: 1'b1, trig: 1'b1};
    localparam reading_t TIMEOUT_RD =
        '{distance: '0, timed_out: 1'b1, done: 1'b1, busy: 1'b0, trig: 1'b0};

    typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;

    // one row of the directed table: a register write or an item
    typedef struct packed {
        row_kind_t         kind;
        cfg_index_t        reg_idx;
        logic [15:0]       value;
        logic              echo;
        logic              start;
        bit                typed;
        reading_t          want;
    } stim_row_t;

    // kinds of register setting used by the random part
    typedef enum int {
        SET_SHORT,
        SET_ZERO_DIV,
        SET_MAX_DIV,
        SET_LONG_TRIGGER,
        SET_MAX_TIMEOUT,
        SET_MIXED
    } setting_kind_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // [0] echo_level, [1] start_request, [7:2] zero
    logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [0] trig_drive, [1] busy_res, [2] done_res, [3] timed_out,
    // [19:4] distance_x100, [23:20] zero
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    cfg_index_t            cfg_index = CFG_CYCLES_PER_US;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int unsigned cycle_count = 0;
    int          mismatches = 0;
    int          results_seen = 0;
    int          next_hold_at = 150;
    int          hold_left = 0;
    wire         calm = (cycle_count >= CALM_FROM) && (cycle_count < CALM_TO);

    // ranger model state and register copies
    phase_t      meas_phase = PH_IDLE;
    logic [7:0]  tick_count = '0;
    us_count_t   us_elapsed = '0;
    logic [7:0]  cfg_us_div = RST_CYCLES_PER_US;
    logic [15:0] cfg_timeout = RST_TIMEOUT_US;
    logic [7:0]  cfg_pre_low = RST_PRE_LOW_US;
    logic [7:0]  cfg_trig_high = RST_TRIG_HIGH_US;

    reading_t    pending_readings[$];
    stim_row_t   directed_rows [28];

    ultrasonic_echo_ranger dut
    (
        .clk,
        .rst_n,
        .s_axis_tvalid,
        .s_axis_tready,
        .s_axis_tdata,
        .m_axis_tvalid,
        .m_axis_tready,
        .m_axis_tdata,
        .cfg_valid,
        .cfg_ready,
        .cfg_index,
        .cfg_data
    );

    always #5 clk = ~clk;

    // cycle counter and run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic void enter_phase(phase_t nxt);
        meas_phase = nxt;
        tick_count = '0;
        us_elapsed = '0;
    endfunction

    // prescaler step, a zero divider counts as one
    function automatic void count_tick();
        int per_us;
        per_us = (cfg_us_div == 0) ? 1 : int'(cfg_us_div);
        if (int'(tick_count) + 1 >= per_us)
        begin
            tick_count = '0;
            if (us_elapsed != TIME_MAX)
                us_elapsed = us_elapsed + 1'b1;
        end
        else
            tick_count = tick_count + 1'b1;
    endfunction

    // echo width in us to hundredths of cm, rounded and saturated
    function automatic logic [DIST_W-1:0] width_to_distance(us_count_t width);
        int unsigned scaled;
        scaled = (int'(width) * 100 + 29) / 58;
        return (scaled > 65535) ? '1 : scaled[DIST_W-1:0];
    endfunction

    // advance the model by one accepted item and give its result item
    function automatic reading_t predict_reading(logic echo, logic start);
        reading_t r;
        r = '0;
        case (meas_phase)
            PH_PRE_LOW:
            begin
                count_tick();
                if (us_elapsed >= cfg_pre_low)
                    enter_phase(PH_TRIG_HIGH);
            end
            PH_TRIG_HIGH:
            begin
                count_tick();
                if (us_elapsed >= cfg_trig_high)
                    enter_phase(PH_WAIT_RISE);
            end
            PH_WAIT_RISE:
            begin
                if (echo)
                    enter_phase(PH_MEASURE);
                else
                begin
                    count_tick();
                    if (us_elapsed >= cfg_timeout)
                    begin
                        r.done = 1'b1;
                        r.timed_out = 1'b1;
                        enter_phase(PH_IDLE);
                    end
                end
            end
            PH_MEASURE:
            begin
                if (!echo)
                begin
                    r.done = 1'b1;
                    r.distance = width_to_distance(us_elapsed);
                    enter_phase(PH_IDLE);
                end
                else
                begin
                    count_tick();
                    if (us_elapsed >= cfg_timeout)
                    begin
                        r.done = 1'b1;
                        r.timed_out = 1'b1;
                        enter_phase(PH_IDLE);
                    end
                end
            end
            default:
            begin
                if (start)
                    enter_phase(PH_PRE_LOW);
            end
        endcase
        r.trig = (meas_phase == PH_TRIG_HIGH);
        r.busy = (meas_phase != PH_IDLE);
        return r;
    endfunction

    function automatic void compare_field(string name, logic [DIST_W-1:0] want,
                                          logic [DIST_W-1:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    // offer one item after random idle cycles; expectation queued in order
    task automatic send_item(input logic echo, input logic start,
                             input bit typed = 1'b0, input reading_t typed_val = '0);
        reading_t predicted;
        cfg_valid <= 1'b0;
        while (!calm && ($urandom_range(99) < IDLE_PCT))
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        predicted = predict_reading(echo, start);
        pending_readings.push_back(typed ? typed_val : predicted);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= IN_TDATA_W'({start, echo});
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // register write once every result item is out; valid left high for the caller
    task automatic write_reg(input cfg_index_t idx, input logic [15:0] value);
        s_axis_tvalid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
        case (idx)
            CFG_CYCLES_PER_US: cfg_us_div = value[7:0];
            CFG_TIMEOUT_US:    cfg_timeout = value;
            CFG_PRE_LOW_US:    cfg_pre_low = value[7:0];
            default:           cfg_trig_high = value[7:0];
        endcase
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    // one measurement: start, echo rises after rise_after wait items and
    // stays high for pulse_for items; noisy runs add glitches and stray starts
    task automatic measure_run(input int rise_after, input int pulse_for, input bit noisy);
        int   waited;
        int   held;
        logic e;
        logic s;
        waited = 0;
        held = 0;
        send_item(1'($urandom_range(0, 1)), 1'b1);
        while (meas_phase != PH_IDLE)
        begin
            s = noisy && ($urandom_range(99) < 10);
            case (meas_phase)
                PH_WAIT_RISE:
                begin
                    e = (waited >= rise_after);
                    waited++;
                end
                PH_MEASURE:
                begin
                    e = (held < pulse_for);
                    held++;
                end
                default:
                    e = 1'($urandom_range(0, 1));
            endcase
            if (noisy && ($urandom_range(99) < 3))
                e = !e;
            send_item(e, s);
        end
        repeat ($urandom_range(0, 3))
            send_item(1'($urandom_range(0, 1)), 1'b0);
    endtask

    // receiver: random stalls, a calm window and long hold-offs
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (results_seen >= next_hold_at)
        begin
            m_axis_tready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            next_hold_at <= next_hold_at * 10;
        end
        else
            m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    // result checker
    always @(posedge clk)
    begin
        reading_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen <= results_seen + 1;
            if (pending_readings.size() == 0)
            begin
                mismatches++;
                $display("%0t: result expected none, got %h", $time, m_axis_tdata);
            end
            else
            begin
                want = pending_readings.pop_front();
                compare_field("trig_drive", DIST_W'(want.trig), DIST_W'(m_axis_tdata[0]));
                compare_field("busy_res", DIST_W'(want.busy), DIST_W'(m_axis_tdata[1]));
                compare_field("done_res", DIST_W'(want.done), DIST_W'(m_axis_tdata[2]));
                compare_field("timed_out", DIST_W'(want.timed_out),
                              DIST_W'(m_axis_tdata[3]));
                compare_field("distance_x100", want.distance, m_axis_tdata[19:4]);
                compare_field("padding", '0, DIST_W'(m_axis_tdata[OUT_TDATA_W-1:20]));
            end
        end
    end

    // stimulus
    initial
    begin
        int            lim;
        int            per_us;
        int            set_items;
        setting_kind_t kind;
        logic [7:0]    div_val;
        logic [7:0]    pre_val;
        logic [7:0]    trig_val;
        logic [15:0]   tmo_val;

        directed_rows = '{
            // idle with reset settings, echo ignored
            '{ROW_ITEM, CFG_CYCLES_PER_US, 16'd0, 1'b1, 1'b0, 1'b1, IDLE_RD},
            '{ROW_ITEM, CFG_CYCLES_PER_US, 16'd0, 1'b0, 1'b0, 1'b1, IDLE_RD},
            // fastest prescaler, zero-length low and high phases, short timeout
            '{ROW_CFG, CFG_CYCLES_PER_US, 16'd1, 1'b0, 1'b0, 1'b0, IDLE_RD},
            '{ROW_CFG, CFG_TIMEOUT_US, 16'd3, 1'b0, 1'b0, 1'b0, IDLE_RD},
            '{ROW_CFG, CFG_PRE_LOW_US, 16'd0, 1'b0, 1'b0, 1'b0, IDLE_RD},
            '{ROW_CFG, CFG_TRIG_HIGH_US, 16'd0, 1'b0, 1'b0, 1'b0, IDLE_RD},
            // start, then start again while busy, then wait for echo until timeout
            '{ROW_ITEM, CFG_CYCLES_PER_US, 16'd0, 1'b0, 1'b1, 1'b1, BUSY_RD},
            '{ROW_ITEM, CFG_CYCLES_PER_US, 16'd0, 1'b1, 1'b1, 1'b1, TRIG_RD},
            '{ROW_ITEM, CFG_CYCLES_PER_US, 16'd0, 1'b0, 1'b0, 1'b0, IDLE_RD},
            '{ROW_ITEM, CFG_CYCLES_PER_US, 16'd0, 1'b0, 1'b0, 1'b0, IDLE_RD},
            '{ROW_ITEM, CFG_CYCLES_PER_US, 16'd0, 1'b0, 1'b0, 1'b0, IDLE_RD},
            // start in the finishing cycle is dropped
            '{ROW_ITEM, CFG_CYCLES_PER_US, 16'd0, 1'b0, 1'b1, 1'b1, TIMEOUT_RD},
            '{ROW_ITEM, CFG_CYCLES_PER_US, 16'd0, 1'b1, 1'b0, 1'b0, IDLE_RD},
            // zero-width echo pulse
            '{ROW_ITEM, CFG_CYCLES_PER_US, 16'd0, 1'b0, 1'b1, 1'b0, IDLE_RD},
            '{ROW_ITEM, CFG_CYCLES_PER_US, 16'd0, 1'b0, 1'b0, 1'b0, IDLE_RD},
            '{ROW_ITEM, CFG_CYCLES_PER_US, 16'd0, 1'b1, 1'b0, 1'b0, IDLE_RD},
            '{ROW_ITEM, CFG_CYCLES_PER_US, 16'd0, 1'b1, 1'b0, 1'b0, IDLE_RD},
            '{ROW_ITEM, CFG_CYCLES_PER_US, 16'd0, 1'b0, 1'b0, 1'b0, IDLE_RD},
            // zero divider with stray upper bits, widest timeout
            '{ROW_CFG, CFG_CYCLES_PER_US, 16'hFF00, 1'b0, 1'b0, 1'b0, IDLE_RD},
            '{ROW_CFG, CFG_TIMEOUT_US, 16'hFFFF, 1'b0, 1'b0, 1'b0, IDLE_RD},
            // short echo pulse measured
            '{ROW_ITEM, CFG_CYCLES_PER_US, 16'd0, 1'b0, 1'b1, 1'b0, IDLE_RD},
            '{ROW_ITEM, CFG_CYCLES_PER_US, 16'd0, 1'b0, 1'b0, 1'b0, IDLE_RD},
            '{ROW_ITEM, CFG_CYCLES_PER_US, 16'd0, 1'b0, 1'b0, 1'b0, IDLE_RD},
            '{ROW_ITEM, CFG_CYCLES_PER_US, 16'd0, 1'b1, 1'b0, 1'b0, IDLE_RD},
            '{ROW_ITEM, CFG_CYCLES_PER_US, 16'd0, 1'b1, 1'b0, 1'b0, IDLE_RD},
            '{ROW_ITEM, CFG_CYCLES_PER_US, 16'd0, 1'b1, 1'b0, 1'b0, IDLE_RD},
            '{ROW_ITEM, CFG_CYCLES_PER_US, 16'd0, 1'b1, 1'b0, 1'b0, IDLE_RD},
            '{ROW_ITEM, CFG_CYCLES_PER_US, 16'd0, 1'b0, 1'b0, 1'b0, IDLE_RD}
        };

        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;

        // directed table
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CFG)
                write_reg(directed_rows[i].reg_idx, directed_rows[i].value);
            else
                send_item(directed_rows[i].echo, directed_rows[i].start,
                          directed_rows[i].typed, directed_rows[i].want);
        end

        // random runs under a series of settings, extremes first
        for (int p = 0; p < SETTINGS_COUNT; p++)
        begin
            kind = (p <= int'(SET_MIXED)) ? setting_kind_t'(p)
                                          : setting_kind_t'($urandom_range(0, 5));
            case (kind)
                SET_SHORT:
                begin
                    div_val = 8'($urandom_range(1, 3));
                    pre_val = 8'($urandom_range(0, 4));
                    trig_val = 8'($urandom_range(0, 4));
                    tmo_val = 16'($urandom_range(1, 20));
                end
                SET_ZERO_DIV:
                begin
                    div_val = 8'd0;
                    pre_val = 8'($urandom_range(0, 3));
                    trig_val = 8'($urandom_range(0, 3));
                    tmo_val = 16'($urandom_range(0, 15));
                end
                SET_MAX_DIV:
                begin
                    div_val = 8'd255;
                    pre_val = 8'd0;
                    trig_val = 8'd1;
                    tmo_val = 16'($urandom_range(1, 2));
                end
                SET_LONG_TRIGGER:
                begin
                    div_val = 8'd1;
                    pre_val = 8'($urandom_range(0, 3));
                    trig_val = 8'd255;
                    tmo_val = 16'($urandom_range(5, 30));
                end
                SET_MAX_TIMEOUT:
                begin
                    div_val = 8'd2;
                    pre_val = 8'd1;
                    trig_val = 8'd1;
                    tmo_val = 16'hFFFF;
                end
                default:
                begin
                    div_val = 8'($urandom_range(1, 8));
                    pre_val = 8'($urandom_range(0, 10));
                    trig_val = 8'($urandom_range(0, 10));
                    tmo_val = 16'($urandom_range(0, 40));
                end
            endcase
            write_reg(CFG_CYCLES_PER_US, {8'($urandom), div_val});
            write_reg(CFG_TIMEOUT_US, tmo_val);
            write_reg(CFG_PRE_LOW_US, {8'($urandom), pre_val});
            write_reg(CFG_TRIG_HIGH_US, {8'($urandom), trig_val});

            // echo timing spread around the timeout so both endings occur
            per_us = (cfg_us_div == 0) ? 1 : int'(cfg_us_div);
            lim = (int'(cfg_timeout) + 2) * per_us;
            if (lim > 60)
                lim = 60;
            set_items = pending_readings.size() + results_seen;
            while (pending_readings.size() + results_seen - set_items < ITEMS_PER_SETTING)
                measure_run($urandom_range(0, lim), $urandom_range(0, lim), 1'b1);
        end

        // drain and report
        s_axis_tvalid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (10)
            @(posedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
